// File: hw/rtl/itbd_pkg.sv
// Shared types, constants and the alphabet lookup for the integer-to-text
// converter. Used by every module of the block; depends on nothing else.
`default_nettype none

package itbd_pkg;

  // Field and storage sizes.
  localparam int VALUE_BITS    = 32;
  localparam int MAX_RADIX     = 32;
  localparam int MIN_RADIX     = 2;
  localparam int RADIX_W       = 6;
  localparam int DIGIT_W       = $clog2(MAX_RADIX);
  localparam int DIVISOR_W     = DIGIT_W + 1;
  localparam int COUNT_W       = $clog2(VALUE_BITS + 1);
  localparam int ADDR_W        = $clog2(VALUE_BITS);
  localparam int CHAR_W        = 8;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int ALPHA_REGS    = 4;
  localparam int CHARS_PER_REG = CFG_W / CHAR_W;
  localparam int CHAR_SEL_W    = $clog2(CHARS_PER_REG);

  // Quotient bits retired per divider cycle, and cycles per digit.
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_CYCLES    = VALUE_BITS / DIV_STEP_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

  localparam logic [CHAR_W-1:0]  MINUS_CHAR  = 8'h2D;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [CFG_W-1:0]   CHARS_LOW_RESET = 64'h3736353433323130;

  typedef logic [ALPHA_REGS-1:0][CFG_W-1:0] alphabet_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIX       = 3'd0,
    CFG_CHARS_LOW   = 3'd1,
    CFG_CHARS_MID   = 3'd2,
    CFG_CHARS_UPPER = 3'd3,
    CFG_CHARS_TOP   = 3'd4
  } cfg_idx_t;

  // Control sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_READ,
    S_SEND
  } state_t;

  // Commands to the divider.
  typedef struct packed {
    logic go;     // start one digit extraction
    logic fresh;  // load a new dividend and divisor instead of the quotient
  } div_ctrl_t;

  // Status from the divider.
  typedef struct packed {
    logic running;
    logic done;      // one-cycle pulse: remainder and quotient are final
    logic quo_zero;  // the quotient left behind is zero
  } div_stat_t;

  // Returns alphabet character idx.
  function automatic logic [CHAR_W-1:0] alpha_char(input alphabet_t a,
                                                   input logic [DIGIT_W-1:0] idx);
    logic [CFG_W-1:0] word;
    word = a[idx[DIGIT_W-1:CHAR_SEL_W]];
    return word[{idx[CHAR_SEL_W-1:0], 3'b000} +: CHAR_W];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/integer_to_base_digits.sv
// Top level of the integer-to-text converter: configuration registers,
// control sequencer, digit store and character output.
// Depends on itbd_pkg and itbd_divider.
`default_nettype none

// Usage:
// Configuration is written through cfg_write/cfg_index/cfg_data while the
// block is idle: index 0 is the radix, indexes 1 to 4 hold the alphabet,
// eight characters per register, lowest byte first. Other indexes are ignored.
// An item is accepted when start is high and busy is low. Its text leaves
// on character/final_res/bad_radix, one character per cycle in which strobe
// is high, most significant digit first, with final_res on the last one.
// A radix below two gives one result with bad_radix set, and a zero value
// gives one alphabet character; both appear the cycle after acceptance and
// busy stays low.
// Otherwise the divider extracts one digit at a time, retiring 4 quotient
// bits per step and then storing the digit; then a leading minus sign is
// sent for a negative value and each digit is read from the digit store,
// then output. Busy stays high until the last character is issued, so no
// new item is taken meanwhile. The receiver cannot stall the block.
// Reset restores radix 10 and the alphabet "01234567" and returns to idle.

module integer_to_base_digits import itbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output logic                  strobe,
  output logic [CHAR_W-1:0]     character,
  output logic                  final_res,
  output logic                  bad_radix
);

  logic [RADIX_W-1:0]    radix;
  alphabet_t             digit_chars;
  state_t                state;
  state_t                state_next;
  logic                  neg;
  logic [COUNT_W-1:0]    digit_count;
  logic [DIGIT_W-1:0]    digit_store [VALUE_BITS];
  logic [DIGIT_W-1:0]    rd_data;
  logic [COUNT_W-1:0]    rd_addr;
  logic                  accept;
  logic                  radix_ok;
  logic [RADIX_W-1:0]    radix_eff;
  logic [VALUE_BITS-1:0] mag;
  logic                  mag_zero;
  logic                  last_digit;
  div_ctrl_t             div_ctrl;
  div_stat_t             div_stat;
  logic [DIGIT_W-1:0]    div_rem;
  logic                  strobe_next;
  logic [CHAR_W-1:0]     character_next;
  logic                  final_res_next;
  logic                  bad_radix_next;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign radix_ok = (radix >= RADIX_W'(MIN_RADIX));
  assign radix_eff = (radix > RADIX_W'(MAX_RADIX)) ? RADIX_W'(MAX_RADIX) : radix;
  assign mag      = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
  assign mag_zero = (mag == '0);
  assign rd_addr  = digit_count - 1'b1;
  // The divider has produced the last digit it can.
  assign last_digit = div_stat.quo_zero || (digit_count == COUNT_W'(VALUE_BITS - 1));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= RADIX_RESET;
      digit_chars <= {{((ALPHA_REGS - 1) * CFG_W){1'b0}}, CHARS_LOW_RESET};
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_RADIX:       radix          <= cfg_data[RADIX_W-1:0];
        CFG_CHARS_LOW:   digit_chars[0] <= cfg_data;
        CFG_CHARS_MID:   digit_chars[1] <= cfg_data;
        CFG_CHARS_UPPER: digit_chars[2] <= cfg_data;
        CFG_CHARS_TOP:   digit_chars[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Divider commands: a fresh load when an item that needs dividing is accepted, then one per further digit.
  always_comb begin
    div_ctrl.go    = 1'b0;
    div_ctrl.fresh = (state == S_IDLE);
    if (state == S_IDLE) begin
      div_ctrl.go = accept && radix_ok && !mag_zero;
    end else if (state == S_DIV) begin
      div_ctrl.go = div_stat.done && !last_digit;
    end
  end

  itbd_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (mag),
    .divisor   (radix_eff),
    .stat      (div_stat),
    .remainder (div_rem)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && radix_ok && !mag_zero) state_next = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done && last_digit) state_next = neg ? S_SIGN : S_READ;
      end
      S_SIGN: state_next = S_READ;
      S_READ: state_next = S_SEND;
      S_SEND: begin
        state_next = (digit_count == COUNT_W'(1)) ? S_IDLE : S_READ;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sign and digit count: counts up while digits are stored, down as sent.
  always_ff @(posedge clk) begin
    if (rst) begin
      neg         <= 1'b0;
      digit_count <= '0;
    end else begin
      priority if (state == S_IDLE && accept) begin
        neg         <= value[VALUE_BITS-1];
        digit_count <= '0;
      end else if (state == S_DIV && div_stat.done) begin
        digit_count <= digit_count + 1'b1;
      end else if (state == S_SEND) begin
        digit_count <= digit_count - 1'b1;
      end else begin
        digit_count <= digit_count;
      end
    end
  end

  // Digit store, least significant digit first.
  always_ff @(posedge clk) begin
    if (state == S_DIV && div_stat.done) begin
      digit_store[digit_count[ADDR_W-1:0]] <= div_rem;
    end
    if (state == S_READ) begin
      rd_data <= digit_store[rd_addr[ADDR_W-1:0]];
    end
  end

  // Result values for the next cycle.
  always_comb begin
    strobe_next    = 1'b0;
    character_next = '0;
    final_res_next = 1'b0;
    bad_radix_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && !radix_ok) begin
          strobe_next    = 1'b1;
          final_res_next = 1'b1;
          bad_radix_next = 1'b1;
        end else if (accept && mag_zero) begin
          strobe_next    = 1'b1;
          final_res_next = 1'b1;
          character_next = alpha_char(digit_chars, '0);
        end
      end
      S_SIGN: begin
        strobe_next    = 1'b1;
        character_next = MINUS_CHAR;
      end
      S_SEND: begin
        strobe_next    = 1'b1;
        character_next = alpha_char(digit_chars, rd_data);
        final_res_next = (digit_count == COUNT_W'(1));
      end
      default: ;
    endcase
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= strobe_next;
    end
    character <= character_next;
    final_res <= final_res_next;
    bad_radix <= bad_radix_next;
  end

  // An item taken with a bad radix answers with an error on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    accept && !radix_ok |=> strobe && bad_radix && final_res && character == '0)
    else $error("bad radix item did not give an error result");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  // The digit count never exceeds the value width.
  assert property (@(posedge clk) disable iff (rst)
    digit_count <= COUNT_W'(VALUE_BITS))
    else $error("digit count overflow");

  // Sending the last digit returns the block to idle.
  assert property (@(posedge clk) disable iff (rst)
    state == S_SEND && digit_count == COUNT_W'(1) |=> !busy && strobe && final_res)
    else $error("last digit did not end the conversion");

endmodule

`default_nettype wire

// File: hw/rtl/itbd_divider.sv
// Serial divider by the radix: shifts the dividend through a register and
// retires DIV_STEP_BITS quotient bits per cycle into the same register.
// Depends on itbd_pkg.
`default_nettype none

module itbd_divider import itbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  div_ctrl_t             ctrl,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [RADIX_W-1:0]    divisor,
  output div_stat_t             stat,
  output logic [DIGIT_W-1:0]    remainder
);

  logic [VALUE_BITS-1:0] quo;
  logic [VALUE_BITS-1:0] quo_next;
  logic [DIGIT_W-1:0]    rem;
  logic [DIGIT_W-1:0]    rem_next;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIV_CNT_W-1:0]  cnt;
  logic                  running;
  logic                  done;

  // DIV_STEP_BITS restoring division steps on the narrow remainder.
  always_comb begin : step_blk
    logic [DIGIT_W:0] trial;
    logic [DIGIT_W:0] diff;
    logic [DIGIT_W-1:0] r;
    logic [VALUE_BITS-1:0] q;
    r = rem;
    q = quo;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      trial = {r, q[VALUE_BITS-1]};
      q     = {q[VALUE_BITS-2:0], 1'b0};
      diff  = trial - dvs;
      if (trial >= dvs) begin
        r    = diff[DIGIT_W-1:0];
        q[0] = 1'b1;
      end else begin
        r = trial[DIGIT_W-1:0];
      end
    end
    rem_next = r;
    quo_next = q;
  end

  // Cycle counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.go) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Dividend/quotient shift register and partial remainder.
  always_ff @(posedge clk) begin
    if (ctrl.go) begin
      rem <= '0;
      if (ctrl.fresh) begin
        quo <= dividend;
        dvs <= divisor[DIVISOR_W-1:0];
      end
    end else if (running) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign stat.running  = running;
  assign stat.done     = done;
  assign stat.quo_zero = (quo == '0);
  assign remainder     = rem;

endmodule

`default_nettype wire
